// File: design/aadf_pkg.sv
// Shared types and constants for the address allow/deny filter.
`default_nettype none

package aadf_pkg;

    // Operation carried in the input tuser field
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CHECK  = 2'd2,
        MODE_SET    = 2'd3
    } aadf_mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2
    } aadf_status_t;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned FLAGS_W = 3;

    // Bit positions inside the entry flags
    localparam int unsigned FLAG_BLACK = 0;
    localparam int unsigned FLAG_WHITE = 1;
    localparam int unsigned FLAG_LOCK  = 2;

    // Word that ripples from one cell to the next
    typedef struct packed {
        logic               free_seen;  // some earlier slot is free
        logic               hit;        // some earlier slot matched the key
        logic [FLAGS_W-1:0] hit_flags;  // flags of the matching slot
        logic               white_any;  // some earlier valid slot is white
    } aadf_chain_t;

    // Commit strobes broadcast to every cell
    typedef struct packed {
        logic add_en;  // store the key in the lowest free slot
        logic del_en;  // free the slot holding the key
    } aadf_cmd_t;

endpackage

`default_nettype wire

// File: design/address_allow_deny_filter.sv
// Top level of the address allow/deny filter: input register, cell chain, result register.
//
// The filter holds a table of ENTRIES 128-bit address keys, each with black, white
// and locked flags, and one pattern bit (1 whitelist, 0 blacklist). Every input word
// is one operation, chosen by s_tuser: add, remove, check or set pattern, and each
// produces exactly one result word. The word is first registered; then all cells
// compare the key in parallel and the chain resolves the match, the lowest free
// slot and the white-flag summary, after which the table is updated and the
// result is registered. Input is taken again in the cycle after that, so a new
// item is accepted only once the previous one has committed, while the previous
// result may still wait in the output register; a result that is not taken holds
// the block only once the next item is ready to commit. The free-slot and match
// chain ripples through all ENTRIES cells during the compare, which sets the clock limit.
// Add fails with invalid on zero flags or a key already present, with full on a
// full table, and on success sets the pattern to white exactly when some stored
// entry is white. Remove of a locked entry reports invalid; an absent key is ok.
// Check reports permit: for a stored key its white flag in whitelist pattern or the
// inverse of its black flag in blacklist pattern; for an unknown key deny in
// whitelist and allow in blacklist. The table starts empty, pattern blacklist.
`default_nettype none

module address_allow_deny_filter
#(
    parameter int unsigned ENTRIES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // [63:0] addr_high, [127:64] addr_low, [130:128] entry_flags,
    // [131] pattern_white, [135:132] zero
    input  wire logic [135:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // [1:0] status, [2] permit, [3] white_now, [7:4] zero
    output      logic [7:0]   m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                       state_reg;
    aadf_pkg::aadf_mode_t         mode_reg;
    logic [aadf_pkg::KEY_W-1:0]   high_reg;
    logic [aadf_pkg::KEY_W-1:0]   low_reg;
    logic [aadf_pkg::FLAGS_W-1:0] flags_reg;
    logic                         pat_reg;
    logic                         white_reg;
    logic                         white_next;
    logic                         out_valid_reg;
    aadf_pkg::aadf_status_t       status_reg;
    aadf_pkg::aadf_status_t       status_next;
    logic                         permit_reg;
    logic                         permit_next;

    aadf_pkg::aadf_chain_t        chain [ENTRIES+1];
    aadf_pkg::aadf_chain_t        tail;
    aadf_pkg::aadf_cmd_t          cmd;
    logic                         commit;
    logic                         add_ok;
    logic                         del_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, white_reg, permit_reg, status_reg};

    // commit once the result register is free or being emptied
    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    assign chain[0] = '0;
    assign tail     = chain[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        aadf_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .key_high  (high_reg),
            .key_low   (low_reg),
            .flags     (flags_reg),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Decide the operation from the chain summary
    always_comb
    begin
        status_next = aadf_pkg::STATUS_OK;
        permit_next = 1'b0;
        white_next  = white_reg;
        add_ok      = 1'b0;
        del_ok      = 1'b0;
        case (mode_reg)
            aadf_pkg::MODE_ADD:
            begin
                if (flags_reg == '0 || tail.hit)
                begin
                    status_next = aadf_pkg::STATUS_INVALID;
                end
                else if (!tail.free_seen)
                begin
                    status_next = aadf_pkg::STATUS_FULL;
                end
                else
                begin
                    add_ok     = 1'b1;
                    // summary of stored entries plus the one going in
                    white_next = tail.white_any | flags_reg[aadf_pkg::FLAG_WHITE];
                end
            end
            aadf_pkg::MODE_REMOVE:
            begin
                if (tail.hit)
                begin
                    if (tail.hit_flags[aadf_pkg::FLAG_LOCK])
                    begin
                        status_next = aadf_pkg::STATUS_INVALID;
                    end
                    else
                    begin
                        del_ok = 1'b1;
                    end
                end
            end
            aadf_pkg::MODE_CHECK:
            begin
                if (tail.hit)
                begin
                    permit_next = white_reg ? tail.hit_flags[aadf_pkg::FLAG_WHITE]
                                            : ~tail.hit_flags[aadf_pkg::FLAG_BLACK];
                end
                else
                begin
                    permit_next = ~white_reg;
                end
            end
            aadf_pkg::MODE_SET:
            begin
                white_next = pat_reg;
            end
            default:
            begin
                status_next = aadf_pkg::STATUS_OK;
            end
        endcase
    end

    assign cmd.add_en = commit && add_ok;
    assign cmd.del_en = commit && del_ok;

    // State, pattern bit and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            white_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        white_reg     <= white_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Input word and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg  <= aadf_pkg::aadf_mode_t'(s_tuser);
            high_reg  <= s_tdata[63:0];
            low_reg   <= s_tdata[127:64];
            flags_reg <= s_tdata[130:128];
            pat_reg   <= s_tdata[131];
        end
        if (commit)
        begin
            status_reg <= status_next;
            permit_reg <= permit_next;
        end
    end

endmodule

`default_nettype wire

// File: design/aadf_cell.sv
// One table slot: key storage, key compare and its link in the cell chain.
`default_nettype none

module aadf_cell
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [aadf_pkg::KEY_W-1:0]    key_high,
    input  wire logic [aadf_pkg::KEY_W-1:0]    key_low,
    input  wire logic [aadf_pkg::FLAGS_W-1:0]  flags,
    input  wire aadf_pkg::aadf_cmd_t           cmd,
    input  wire aadf_pkg::aadf_chain_t         chain_in,
    output aadf_pkg::aadf_chain_t              chain_out
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [aadf_pkg::KEY_W-1:0]   high_reg;
    logic [aadf_pkg::KEY_W-1:0]   low_reg;
    logic [aadf_pkg::FLAGS_W-1:0] flags_reg;
    logic                         match;
    logic                         claim;

    assign match = valid_reg && (high_reg == key_high) && (low_reg == key_low);
    // lowest free slot: free here and no free slot before
    assign claim = !valid_reg && !chain_in.free_seen;

    always_comb
    begin
        chain_out.free_seen = chain_in.free_seen | ~valid_reg;
        chain_out.hit       = chain_in.hit | match;
        chain_out.hit_flags = chain_in.hit_flags
                            | (match ? flags_reg : {aadf_pkg::FLAGS_W{1'b0}});
        chain_out.white_any = chain_in.white_any
                            | (valid_reg & flags_reg[aadf_pkg::FLAG_WHITE]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.add_en && claim)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.del_en && match)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_en && claim)
        begin
            high_reg  <= key_high;
            low_reg   <= key_low;
            flags_reg <= flags;
        end
    end

endmodule

`default_nettype wire

// File: design/aadf_checker.sv
// Port-level assertions for the address allow/deny filter and their bind.
`default_nettype none

module aadf_assertions
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [135:0] s_tdata,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [7:0]   m_tdata
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one item at a time: no input right after an accepted word
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // an accepted word is always followed by a valid result word
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result word after an accepted item");

    // status never takes the unused code, failures never permit
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] <= aadf_pkg::STATUS_FULL)
                     && ((m_tdata[1:0] == aadf_pkg::STATUS_OK) || !m_tdata[2]))
        else $error("bad status or permit on a failed operation");

endmodule

bind address_allow_deny_filter aadf_assertions u_aadf_assertions
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/aadf_checker.sv
// Checker for the address allow/deny filter: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module aadf_checker
#(
    parameter int unsigned ENTRIES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    // [63:0] addr_high, [127:64] addr_low, [130:128] entry_flags,
    // [131] pattern_white, [135:132] zero
    input  wire logic [135:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    // [1:0] status, [2] permit, [3] white_now, [7:4] zero
    input  wire logic [7:0]   m_tdata,
    output int                fail_count,
    output int                result_count,
    output int                pending
);

    typedef struct packed {
        aadf_pkg::aadf_status_t status;
        logic                   permit;
        logic                   white_now;
    } verdict_t;

    // Shadow copy of the filter table
    logic                         slot_used  [ENTRIES];
    logic [aadf_pkg::KEY_W-1:0]   slot_hi    [ENTRIES];
    logic [aadf_pkg::KEY_W-1:0]   slot_lo    [ENTRIES];
    logic [aadf_pkg::FLAGS_W-1:0] slot_flags [ENTRIES];
    logic                         white_mode;

    verdict_t verdict_q [$];

    // Apply one operation to the shadow table and return the verdict it yields.
    function automatic verdict_t predict_verdict(aadf_pkg::aadf_mode_t mode,
                                                 logic [aadf_pkg::KEY_W-1:0] hi,
                                                 logic [aadf_pkg::KEY_W-1:0] lo,
                                                 logic [aadf_pkg::FLAGS_W-1:0] flags,
                                                 logic pat);
        verdict_t v;
        int       hit;
        int       spare;
        hit   = -1;
        spare = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo)
                hit = i;
            if (spare < 0 && !slot_used[i])
                spare = i;
        end
        v.status = aadf_pkg::STATUS_OK;
        v.permit = 1'b0;
        case (mode)
            aadf_pkg::MODE_ADD:
            begin
                if (flags == '0 || hit >= 0)
                    v.status = aadf_pkg::STATUS_INVALID;
                else if (spare < 0)
                    v.status = aadf_pkg::STATUS_FULL;
                else
                begin
                    slot_used[spare]  = 1'b1;
                    slot_hi[spare]    = hi;
                    slot_lo[spare]    = lo;
                    slot_flags[spare] = flags;
                    white_mode        = 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_used[i] && slot_flags[i][aadf_pkg::FLAG_WHITE])
                            white_mode = 1'b1;
                end
            end
            aadf_pkg::MODE_REMOVE:
            begin
                if (hit >= 0)
                begin
                    if (slot_flags[hit][aadf_pkg::FLAG_LOCK])
                        v.status = aadf_pkg::STATUS_INVALID;
                    else
                        slot_used[hit] = 1'b0;
                end
            end
            aadf_pkg::MODE_CHECK:
            begin
                if (hit >= 0)
                    v.permit = white_mode ? slot_flags[hit][aadf_pkg::FLAG_WHITE]
                                          : !slot_flags[hit][aadf_pkg::FLAG_BLACK];
                else
                    v.permit = !white_mode;
            end
            default:
                white_mode = pat;
        endcase
        v.white_now = white_mode;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        int       errs;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_used[i] = 1'b0;
            white_mode = 1'b0;
            verdict_q.delete();
            fail_count   <= 0;
            result_count <= 0;
            pending      <= 0;
        end
        else
        begin
            errs = 0;
            // Retire the oldest prediction first; a word taken at this edge is older than any
            // word accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result word expected none, got %h", $time, m_tdata);
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_tdata[1:0]);
                        errs++;
                    end
                    if (m_tdata[2] !== want.permit)
                    begin
                        $display("%0t: permit expected %0b, got %0b",
                                 $time, want.permit, m_tdata[2]);
                        errs++;
                    end
                    if (m_tdata[3] !== want.white_now)
                    begin
                        $display("%0t: white_now expected %0b, got %0b",
                                 $time, want.white_now, m_tdata[3]);
                        errs++;
                    end
                    if (m_tdata[7:4] !== 4'b0)
                    begin
                        $display("%0t: padding expected 0, got %h", $time, m_tdata[7:4]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_verdict(aadf_pkg::aadf_mode_t'(s_tuser),
                                                    s_tdata[63:0], s_tdata[127:64],
                                                    s_tdata[130:128], s_tdata[131]));
            fail_count <= fail_count + errs;
            pending    <= verdict_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the address allow/deny filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned ENTRIES     = 16;
    localparam int          POOL        = 24;      // more keys than slots, so the table fills
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          LONG_STALL  = 240;     // receiver hold-off, in cycles
    localparam int          TAIL_CYCLES = 20;

    localparam logic [aadf_pkg::FLAGS_W-1:0] F_BLACK = 3'(1 << aadf_pkg::FLAG_BLACK);
    localparam logic [aadf_pkg::FLAGS_W-1:0] F_WHITE = 3'(1 << aadf_pkg::FLAG_WHITE);
    localparam logic [aadf_pkg::FLAGS_W-1:0] F_LOCK  = 3'(1 << aadf_pkg::FLAG_LOCK);

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    int fail_count;
    int result_count;
    int pending;

    int words_sent;
    bit quiet;          // no idling on either side
    int stall_asks;     // long receiver hold-offs requested by the stimulus
    int stall_served;   // long receiver hold-offs done by the receiver

    logic [aadf_pkg::KEY_W-1:0] pool_hi [POOL];
    logic [aadf_pkg::KEY_W-1:0] pool_lo [POOL];

    address_allow_deny_filter #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    aadf_checker #(
        .ENTRIES (ENTRIES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .result_count (result_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one word and hold it until the filter takes it. Insert a random idle burst first
    // unless the run is in its quiet part.
    task automatic send_word(aadf_pkg::aadf_mode_t mode, logic [aadf_pkg::KEY_W-1:0] hi,
                             logic [aadf_pkg::KEY_W-1:0] lo,
                             logic [aadf_pkg::FLAGS_W-1:0] flags, logic pat);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, pat, flags, lo, hi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Pick an operation by weight. Draw most keys from the pool so adds collide, removes hit
    // and checks match; the rest are fresh random keys. Keep locked entries fairly rare so
    // removes can still drain the table.
    task automatic send_random(int add_w, int rem_w, int chk_w, int set_w);
        aadf_pkg::aadf_mode_t         mode;
        logic [aadf_pkg::KEY_W-1:0]   hi;
        logic [aadf_pkg::KEY_W-1:0]   lo;
        logic [aadf_pkg::FLAGS_W-1:0] flags;
        int                           pick;
        int                           k;
        pick = $urandom_range(0, add_w + rem_w + chk_w + set_w - 1);
        if (pick < add_w)
            mode = aadf_pkg::MODE_ADD;
        else if (pick < add_w + rem_w)
            mode = aadf_pkg::MODE_REMOVE;
        else if (pick < add_w + rem_w + chk_w)
            mode = aadf_pkg::MODE_CHECK;
        else
            mode = aadf_pkg::MODE_SET;
        if ($urandom_range(0, 99) < 85)
        begin
            k  = $urandom_range(0, POOL - 1);
            hi = pool_hi[k];
            lo = pool_lo[k];
        end
        else
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        flags = 3'($urandom_range(0, 7));
        if (flags[aadf_pkg::FLAG_LOCK] && $urandom_range(0, 2) != 0)
            flags[aadf_pkg::FLAG_LOCK] = 1'b0;
        send_word(mode, hi, lo, flags, 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold off until every word sent so far has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_count < words_sent)
            @(posedge clk);
    endtask

    // Receiver: alternate ready and idle bursts; serve a long hold-off when one is asked for,
    // counting its cycles here while the sender keeps offering words.
    initial
    begin : rx_side
        int span;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_asks != stall_served)
            begin
                stall_served = stall_served + 1;
                m_tready <= 1'b0;
                span = LONG_STALL;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 9);
            end
            else
            begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 12);
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= aadf_pkg::MODE_CHECK;
        quiet        <= 1'b0;
        stall_asks   <= 0;
        words_sent   = 0;

        // Build the key pool: the four corner keys, then random keys, some sharing one half
        // with their neighbor so that only the full 128-bit compare tells them apart.
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[2] = '1;
        pool_lo[2] = '0;
        pool_hi[3] = '0;
        pool_lo[3] = '1;
        for (int i = 4; i < POOL; i++)
        begin
            pool_hi[i] = (i % 4 == 1) ? pool_hi[i-1] : {$urandom, $urandom};
            pool_lo[i] = (i % 4 == 2) ? pool_lo[i-1] : {$urandom, $urandom};
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, blacklist pattern and empty table to start.
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[1], pool_lo[1], 3'd7, 1'b1);  // unknown, allowed
        send_word(aadf_pkg::MODE_ADD,    pool_hi[1], pool_lo[1], 3'd0, 1'b1);  // zero flags
        send_word(aadf_pkg::MODE_ADD,    pool_hi[1], pool_lo[1], F_BLACK, 1'b1);
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[1], pool_lo[1], 3'd0, 1'b0);  // black, denied
        send_word(aadf_pkg::MODE_ADD,    pool_hi[1], pool_lo[1], F_WHITE, 1'b0);  // duplicate
        send_word(aadf_pkg::MODE_ADD,    pool_hi[0], pool_lo[0], F_WHITE | F_LOCK,
                  1'b0);  // goes white
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[0], pool_lo[0], 3'd0, 1'b0);  // white, allowed
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[2], pool_lo[2], 3'd0, 1'b1);  // unknown, denied
        send_word(aadf_pkg::MODE_REMOVE, pool_hi[0], pool_lo[0], 3'd0, 1'b1);  // locked entry
        send_word(aadf_pkg::MODE_REMOVE, pool_hi[3], pool_lo[3], 3'd7, 1'b1);  // absent key
        send_word(aadf_pkg::MODE_SET,    pool_hi[2], pool_lo[2], 3'd7, 1'b0);  // to blacklist
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[0], pool_lo[0], 3'd7, 1'b1);  // no black flag
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[2], pool_lo[2], 3'd0, 1'b0);  // unknown, allowed
        send_word(aadf_pkg::MODE_REMOVE, pool_hi[1], pool_lo[1], 3'd0, 1'b0);  // unlocked, freed
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[1], pool_lo[1], 3'd0, 1'b0);  // gone again
        send_word(aadf_pkg::MODE_ADD,    pool_hi[2], pool_lo[2], 3'd7, 1'b0);  // all flags, white
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[2], pool_lo[2], 3'd0, 1'b0);
        send_word(aadf_pkg::MODE_SET,    pool_hi[3], pool_lo[3], 3'd0, 1'b1);
        send_word(aadf_pkg::MODE_ADD,    pool_hi[3], pool_lo[3], F_BLACK | F_LOCK,
                  1'b0);  // stays white
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[3], pool_lo[3], 3'd0, 1'b0);  // no white flag
        send_word(aadf_pkg::MODE_SET,    pool_hi[0], pool_lo[0], 3'd0, 1'b0);
        send_word(aadf_pkg::MODE_CHECK,  pool_hi[3], pool_lo[3], 3'd7, 1'b1);  // black, denied
        drain();

        // Fill the table well past its size so adds start reporting full.
        repeat (120) send_random(6, 1, 3, 1);
        drain();

        // Hold the receiver off for a long stretch while words keep coming, so the filter
        // backs up and stalls its input.
        stall_asks <= stall_asks + 1;
        repeat (150) send_random(3, 3, 4, 1);
        drain();

        // Drain the table with a mix weighted toward removes.
        repeat (80) send_random(1, 6, 3, 1);
        drain();

        // Quiet part: no idling on either side.
        quiet <= 1'b1;
        repeat (100) send_random(3, 3, 4, 1);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
design/aadf_pkg.sv
design/aadf_cell.sv
design/address_allow_deny_filter.sv
design/aadf_checker.sv
verif/aadf_checker.sv
verif/testbench.sv
